// ----- sv/urfg_pkg.sv -----
package urfg_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_VALUE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOAT_FORMAT = 2'd1;

    // Output float encodings
    localparam logic [1:0] FMT_FP32 = 2'd0;
    localparam logic [1:0] FMT_FP16 = 2'd1;
    localparam logic [1:0] FMT_BF16 = 2'd2;

    // splitmix64 constants
    localparam logic [63:0] GOLDEN_INC = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX_MUL1   = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] MIX_MUL2   = 64'h94D0_49BB_1331_11EB;

    // xoroshiro128+ rotate and shift amounts
    localparam int ROT_A   = 55;
    localparam int ROT_B   = 36;
    localparam int SHIFT_A = 14;

    typedef enum logic [2:0] {
        SEED_IDLE,
        SEED_INC,
        SEED_MUL1,
        SEED_ADD1,
        SEED_MUL2,
        SEED_ADD2
    } seed_state_t;

    // State word load from the seeding sequencer
    typedef struct packed {
        logic        load_a;
        logic        load_b;
        logic [63:0] word;
    } seed_load_t;

    // Sum stage to encode stage
    typedef struct packed {
        logic        valid;
        logic        last;
        logic [63:0] sum;
    } sum_item_t;

endpackage

// ----- sv/urfg_seeder.sv -----
module urfg_seeder
    import urfg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] seed,
    output logic        busy,
    output seed_load_t  load
);

    seed_state_t state_reg, state_next;
    logic        draw_reg, draw_next;
    logic [63:0] ctr_reg, ctr_next;
    logic [63:0] z_reg, z_next;
    logic [63:0] pp_lo_reg, pp_lo_next;
    logic [31:0] pp_x_reg, pp_x_next;

    logic [63:0] mul_const;
    logic [63:0] prod_lo;
    logic [63:0] prod_hl;
    logic [63:0] prod_lh;
    logic [31:0] pp_cross;
    logic [63:0] fold;
    logic [63:0] ctr_inc;

    // Split 64x64 low product into three 32x32 products
    assign mul_const = (state_reg == SEED_MUL2) ? MIX_MUL2 : MIX_MUL1;
    assign prod_lo   = 64'(z_reg[31:0]) * 64'(mul_const[31:0]);
    assign prod_hl   = 64'(z_reg[63:32]) * 64'(mul_const[31:0]);
    assign prod_lh   = 64'(z_reg[31:0]) * 64'(mul_const[63:32]);
    assign pp_cross  = prod_hl[31:0] + prod_lh[31:0];
    assign fold      = pp_lo_reg + {pp_x_reg, 32'b0};
    assign ctr_inc   = ctr_reg + GOLDEN_INC;

    assign busy = (state_reg != SEED_IDLE);

    always_comb
    begin
        state_next = state_reg;
        if (start)
        begin
            state_next = SEED_INC;
        end
        else
        begin
            unique case (state_reg)
                SEED_IDLE: state_next = SEED_IDLE;
                SEED_INC:  state_next = SEED_MUL1;
                SEED_MUL1: state_next = SEED_ADD1;
                SEED_ADD1: state_next = SEED_MUL2;
                SEED_MUL2: state_next = SEED_ADD2;
                SEED_ADD2: state_next = draw_reg ? SEED_IDLE : SEED_INC;
                default:   state_next = SEED_IDLE;
            endcase
        end
    end

    always_comb
    begin
        ctr_next    = ctr_reg;
        z_next      = z_reg;
        pp_lo_next  = pp_lo_reg;
        pp_x_next   = pp_x_reg;
        draw_next   = draw_reg;
        load.load_a = 1'b0;
        load.load_b = 1'b0;
        load.word   = fold ^ (fold >> 31);
        if (start)
        begin
            ctr_next  = seed;
            draw_next = 1'b0;
        end
        else
        begin
            unique case (state_reg)
                SEED_INC:
                begin
                    ctr_next = ctr_inc;
                    z_next   = ctr_inc ^ (ctr_inc >> 30);
                end
                SEED_MUL1, SEED_MUL2:
                begin
                    pp_lo_next = prod_lo;
                    pp_x_next  = pp_cross;
                end
                SEED_ADD1:
                begin
                    z_next = fold ^ (fold >> 27);
                end
                SEED_ADD2:
                begin
                    load.load_a = !draw_reg;
                    load.load_b = draw_reg;
                    draw_next   = 1'b1;
                end
                default:
                begin
                    ctr_next = ctr_reg;
                end
            endcase
        end
    end

    // Reset starts a load from seed zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEED_INC;
            draw_reg  <= 1'b0;
            ctr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            draw_reg  <= draw_next;
            ctr_reg   <= ctr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        z_reg     <= z_next;
        pp_lo_reg <= pp_lo_next;
        pp_x_reg  <= pp_x_next;
    end

endmodule

// ----- sv/urfg_core.sv -----
module urfg_core
    import urfg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic       last_in,
    input  seed_load_t load,
    input  logic       enc_ready,
    output logic       stage_ready,
    output sum_item_t  item
);

    logic [63:0] word_a_reg, word_a_next;
    logic [63:0] word_b_reg, word_b_next;
    logic        valid_reg, valid_next;
    logic        last_reg, last_next;
    logic [63:0] sum_reg, sum_next;
    logic [63:0] mix;

    assign stage_ready = !valid_reg || enc_ready;
    assign mix         = word_a_reg ^ word_b_reg;

    always_comb
    begin
        word_a_next = word_a_reg;
        word_b_next = word_b_reg;
        sum_next    = sum_reg;
        last_next   = last_reg;
        valid_next  = valid_reg && !enc_ready;
        if (load.load_a)
        begin
            word_a_next = load.word;
        end
        if (load.load_b)
        begin
            word_b_next = load.word;
        end
        if (take)
        begin
            // Advance the generator; the sum uses the words before the step
            sum_next    = word_a_reg + word_b_reg;
            last_next   = last_in;
            valid_next  = 1'b1;
            word_a_next = {word_a_reg[63-ROT_A:0], word_a_reg[63:64-ROT_A]}
                        ^ mix ^ (mix << SHIFT_A);
            word_b_next = {mix[63-ROT_B:0], mix[63:64-ROT_B]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_a_reg <= word_a_next;
        word_b_reg <= word_b_next;
        sum_reg    <= sum_next;
        last_reg   <= last_next;
    end

    assign item.valid = valid_reg;
    assign item.last  = last_reg;
    assign item.sum   = sum_reg;

endmodule

// ----- sv/urfg_encode.sv -----
module urfg_encode
    import urfg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  sum_item_t   item,
    input  logic [1:0]  fmt,
    input  logic        out_ready,
    output logic        enc_ready,
    output logic        out_valid,
    output logic [31:0] out_sample,
    output logic [63:0] out_raw,
    output logic        out_last
);

    logic        valid_reg, valid_next;
    logic [31:0] sample_reg, sample_next;
    logic [63:0] raw_reg, raw_next;
    logic        last_reg, last_next;

    logic [23:0] n_fp32;
    logic [10:0] n_fp16;
    logic [7:0]  n_bf16;
    logic [23:0] n24;
    logic [4:0]  lead;
    logic [23:0] norm;
    logic [7:0]  expo8;
    logic [4:0]  expo5;
    logic [31:0] bits;

    assign enc_ready = !valid_reg || out_ready;

    // 2^k - m, left-aligned in a 24-bit field so one normalizer serves all formats
    assign n_fp32 = 24'h80_0000 - {1'b0, item.sum[63:41]};
    assign n_fp16 = 11'h400 - {1'b0, item.sum[63:54]};
    assign n_bf16 = 8'h80 - {1'b0, item.sum[63:57]};

    always_comb
    begin
        case (fmt)
            FMT_FP16: n24 = {n_fp16, 13'b0};
            FMT_BF16: n24 = {n_bf16, 16'b0};
            default:  n24 = n_fp32;
        endcase
    end

    // n24 is never zero
    always_comb
    begin
        lead = '0;
        for (int i = 0; i < 24; i++)
        begin
            if (n24[i])
            begin
                lead = 5'(i);
            end
        end
    end

    assign norm  = n24 << (5'd23 - lead);
    assign expo8 = {3'b0, lead} + 8'd104;
    assign expo5 = lead - 5'd8;

    always_comb
    begin
        case (fmt)
            FMT_FP16: bits = {16'b0, 1'b0, expo5, norm[22:13]};
            FMT_BF16: bits = {16'b0, 1'b0, expo8, norm[22:16]};
            default:  bits = {1'b0, expo8, norm[22:0]};
        endcase
    end

    always_comb
    begin
        valid_next  = valid_reg && !out_ready;
        sample_next = sample_reg;
        raw_next    = raw_reg;
        last_next   = last_reg;
        if (item.valid && enc_ready)
        begin
            valid_next  = 1'b1;
            sample_next = bits;
            raw_next    = item.sum;
            last_next   = item.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        raw_reg    <= raw_next;
        last_reg   <= last_next;
    end

    assign out_valid  = valid_reg;
    assign out_sample = sample_reg;
    assign out_raw    = raw_reg;
    assign out_last   = last_reg;

endmodule

// ----- sv/uniform_random_float_generator.sv -----
// Uniform random source: a xoroshiro128+ generator (rotates 55 and 36,
// shift 14) whose two 64-bit state words are loaded by two splitmix64 draws
// of a 64-bit seed. Every input item advances the generator once and yields
// one output item: the raw 64-bit sum of the state words before the step and
// a float in (0,1] encoding (2^k - m)/2^k exactly, where m is the top k bits
// of that sum (k = 23 fp32, 10 fp16, 7 bf16; format code 3 gives fp32). The
// block takes one item per clock while m_tready is held high and no seed
// load runs; the xor/rotate step with the 64-bit add sits in the first
// stage, the normalizer and float packing in the output register stage.
// After reset and after each seed write, a sequencer runs the splitmix64
// load (five steps per draw, the 64-bit constant multiplies split into
// 32x32 products), and s_tready stays low for that time. Configuration
// writes are always taken; write registers only while no item is in flight.
module uniform_random_float_generator
    import urfg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    // Input items
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,    // [0] last_in_batch, [7:1] zero

    // Output items
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [95:0]          m_tdata,    // [31:0] sample_bits, [95:32] raw_word
    output logic                 m_tlast,    // last_out

    // Register writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data
);

    logic       cfg_write;
    logic       seed_start;
    logic [1:0] format_reg, format_next;
    logic       seed_busy;
    seed_load_t seed_load;
    logic       stage_ready;
    logic       enc_ready;
    logic       take;
    sum_item_t  sum_item;
    logic [31:0] out_sample;
    logic [63:0] out_raw;

    assign cfg_ready  = 1'b1;
    assign cfg_write  = cfg_valid && cfg_ready;
    assign seed_start = cfg_write && (cfg_index == CFG_SEED_VALUE);

    // Hold the format; writes to unknown indexes drop
    always_comb
    begin
        format_next = format_reg;
        if (cfg_write && (cfg_index == CFG_FLOAT_FORMAT))
        begin
            format_next = cfg_data[1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg <= FMT_FP32;
        end
        else
        begin
            format_reg <= format_next;
        end
    end

    // Accept an item only once the state words are loaded
    assign s_tready = stage_ready && !seed_busy;
    assign take     = s_tvalid && s_tready;

    urfg_seeder u_seeder (
        .clk   (clk),
        .rst_n (rst_n),
        .start (seed_start),
        .seed  (cfg_data),
        .busy  (seed_busy),
        .load  (seed_load)
    );

    urfg_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .last_in     (s_tdata[0]),
        .load        (seed_load),
        .enc_ready   (enc_ready),
        .stage_ready (stage_ready),
        .item        (sum_item)
    );

    urfg_encode u_encode (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (sum_item),
        .fmt        (format_reg),
        .out_ready  (m_tready),
        .enc_ready  (enc_ready),
        .out_valid  (m_tvalid),
        .out_sample (out_sample),
        .out_raw    (out_raw),
        .out_last   (m_tlast)
    );

    assign m_tdata = {out_raw, out_sample};

endmodule
